// ===== rtl/nms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the box non-maximum suppression block.
// Used by nms_queue, nms_front, nms_back and the top level; no dependencies.
package nms_pkg;

    // Candidate store
    localparam int MAX_CAND    = 64;
    localparam int CAND_AW     = $clog2(MAX_CAND);
    localparam int CNT_W       = $clog2(MAX_CAND + 1);

    // Classes per row; the counter saturates at MAX_CLASSES
    localparam int MAX_CLASSES = 256;
    localparam int CLS_CNT_W   = $clog2(MAX_CLASSES + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int COORD_W = 14;
    localparam int EDGE_W  = 16;
    localparam int SCORE_W = 16;
    localparam int CLASS_W = 8;
    localparam int AREA_W  = 2 * COORD_W;
    localparam int UNI_W   = AREA_W + 1;
    localparam int PROD_W  = UNI_W + SCORE_W;

    // Configuration registers
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_SCORE_THR = 1'b0;
    localparam logic [CFG_AW-1:0] REG_IOU_THR   = 1'b1;
    localparam logic [SCORE_W-1:0] SCORE_THR_RST = 16'd26214;
    localparam logic [SCORE_W-1:0] IOU_THR_RST   = 16'd32768;

    // Input item codes
    localparam logic OP_BOX   = 1'b0;
    localparam logic OP_CLASS = 1'b1;

    // One stored candidate box in corner form
    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic [SCORE_W-1:0]       score;
        logic [CLASS_W-1:0]       class_id;
        logic [AREA_W-1:0]        area;
    } cand_t;

    // Queue entry: a candidate, a frame end, or both
    typedef struct packed {
        logic  is_cand;
        logic  is_end;
        cand_t cand;
    } q_entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEL,
        ST_PICK,
        ST_SUPP
    } back_state_t;

endpackage

// ===== rtl/nms_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of candidate items between the front and back ends.
// Depends on nms_pkg.
module nms_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nms_pkg::q_entry_t   push_data,
    input  logic                pop,
    output nms_pkg::q_entry_t   head,
    output nms_pkg::q_stat_t    stat
);

    nms_pkg::q_entry_t                     store_reg [nms_pkg::QUEUE_DEPTH];
    logic [nms_pkg::QUEUE_AW-1:0]          wr_ptr_reg;
    logic [nms_pkg::QUEUE_AW-1:0]          rd_ptr_reg;
    logic [nms_pkg::QCNT_W-1:0]            count_reg;
    logic [nms_pkg::QCNT_W-1:0]            count_next;

    assign stat.full  = (count_reg == nms_pkg::QCNT_W'(nms_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = store_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("queue read while empty");

endmodule

// ===== rtl/nms_front.sv =====
`timescale 1ns / 1ps
// Front end: takes box and class score items, tracks the best class of the row,
// forms the score, filters on the threshold and queues candidates and frame ends. Uses nms_pkg.
module nms_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [nms_pkg::COORD_W-1:0]        pos_x,
    input  logic [nms_pkg::COORD_W-1:0]        pos_y,
    input  logic [nms_pkg::COORD_W-1:0]        box_width,
    input  logic [nms_pkg::COORD_W-1:0]        box_height,
    input  logic [nms_pkg::SCORE_W-1:0]        objectness,
    input  logic [nms_pkg::SCORE_W-1:0]        class_score,
    input  logic                               last_class,
    input  logic                               last_row,
    input  logic [nms_pkg::SCORE_W-1:0]        score_thr,
    input  nms_pkg::q_stat_t                   q_stat,
    output logic                               q_push,
    output nms_pkg::q_entry_t                  q_data
);

    // Row state
    logic [nms_pkg::COORD_W-1:0]   cx_reg, cy_reg, w_reg, h_reg;
    logic [nms_pkg::SCORE_W-1:0]   obj_reg;
    logic [nms_pkg::SCORE_W-1:0]   best_reg;
    logic [nms_pkg::CLASS_W-1:0]   best_cls_reg;
    logic [nms_pkg::CLS_CNT_W-1:0] cls_cnt_reg;

    // Row finish stage
    logic                          fin_v_reg;
    logic                          fin_v_next;
    logic                          fin_end_reg;
    logic [nms_pkg::COORD_W-1:0]   fin_cx_reg, fin_cy_reg, fin_w_reg, fin_h_reg;
    logic [nms_pkg::SCORE_W-1:0]   fin_obj_reg;
    logic [nms_pkg::SCORE_W-1:0]   fin_best_reg;
    logic [nms_pkg::CLASS_W-1:0]   fin_cls_reg;

    logic                          accept;
    logic                          take;
    logic [nms_pkg::SCORE_W-1:0]   best_upd;
    logic [nms_pkg::CLASS_W-1:0]   cls_upd;
    logic                          fin_done;
    logic [2*nms_pkg::SCORE_W-1:0] prod;
    logic [nms_pkg::SCORE_W-1:0]   sc;
    logic                          pass;
    logic [nms_pkg::EDGE_W-1:0]    left_w, top_w;

    assign in_stall = fin_v_reg && q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign fin_done = fin_v_reg && !q_stat.full;

    // Finish stage occupancy: a closing row refills it as it drains
    assign fin_v_next = (fin_v_reg && !fin_done)
        || (accept && (op == nms_pkg::OP_CLASS) && last_class);

    // Best class so far including this score; lowest index wins ties
    always_comb
    begin
        take = (cls_cnt_reg < nms_pkg::CLS_CNT_W'(nms_pkg::MAX_CLASSES))
            && ((cls_cnt_reg == '0) || (class_score > best_reg));
        best_upd = take ? class_score : best_reg;
        cls_upd  = take ? cls_cnt_reg[nms_pkg::CLASS_W-1:0] : best_cls_reg;
    end

    // Score, threshold and corner conversion of the finished row
    always_comb
    begin
        prod   = (2*nms_pkg::SCORE_W)'(fin_obj_reg) * (2*nms_pkg::SCORE_W)'(fin_best_reg);
        sc     = prod[2*nms_pkg::SCORE_W-1:nms_pkg::SCORE_W];
        pass   = sc > score_thr;
        left_w = {2'b00, fin_cx_reg} - {3'b000, fin_w_reg[nms_pkg::COORD_W-1:1]};
        top_w  = {2'b00, fin_cy_reg} - {3'b000, fin_h_reg[nms_pkg::COORD_W-1:1]};
        q_data.is_cand       = pass;
        q_data.is_end        = fin_end_reg;
        q_data.cand.left     = left_w;
        q_data.cand.top      = top_w;
        q_data.cand.right    = left_w + {2'b00, fin_w_reg};
        q_data.cand.bottom   = top_w + {2'b00, fin_h_reg};
        q_data.cand.score    = sc;
        q_data.cand.class_id = fin_cls_reg;
        q_data.cand.area     = nms_pkg::AREA_W'(fin_w_reg) * nms_pkg::AREA_W'(fin_h_reg);
        q_push = fin_done && (pass || fin_end_reg);
    end

    // Row tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg       <= '0;
            cy_reg       <= '0;
            w_reg        <= '0;
            h_reg        <= '0;
            obj_reg      <= '0;
            best_reg     <= '0;
            best_cls_reg <= '0;
            cls_cnt_reg  <= '0;
            fin_v_reg    <= 1'b0;
        end
        else
        begin
            fin_v_reg <= fin_v_next;
            if (accept)
            begin
                if (op == nms_pkg::OP_BOX)
                begin
                    cx_reg       <= pos_x;
                    cy_reg       <= pos_y;
                    w_reg        <= box_width;
                    h_reg        <= box_height;
                    obj_reg      <= objectness;
                    best_reg     <= '0;
                    best_cls_reg <= '0;
                    cls_cnt_reg  <= '0;
                end
                else if (last_class)
                begin
                    best_reg     <= '0;
                    best_cls_reg <= '0;
                    cls_cnt_reg  <= '0;
                end
                else
                begin
                    best_reg     <= best_upd;
                    best_cls_reg <= cls_upd;
                    if (cls_cnt_reg < nms_pkg::CLS_CNT_W'(nms_pkg::MAX_CLASSES))
                    begin
                        cls_cnt_reg <= cls_cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Finish stage payload
    always_ff @(posedge clk)
    begin
        if (accept && (op == nms_pkg::OP_CLASS) && last_class)
        begin
            fin_end_reg  <= last_row;
            fin_cx_reg   <= cx_reg;
            fin_cy_reg   <= cy_reg;
            fin_w_reg    <= w_reg;
            fin_h_reg    <= h_reg;
            fin_obj_reg  <= obj_reg;
            fin_best_reg <= best_upd;
            fin_cls_reg  <= cls_upd;
        end
    end

endmodule

// ===== rtl/nms_back.sv =====
`timescale 1ns / 1ps
// Back end: candidate store, repeated best-score selection and IoU suppression
// passes, and the result register. Uses nms_pkg.
module nms_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nms_pkg::q_entry_t                  q_head,
    input  nms_pkg::q_stat_t                   q_stat,
    output logic                               q_pop,
    input  logic [nms_pkg::SCORE_W-1:0]        iou_thr,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [nms_pkg::EDGE_W-1:0]  left,
    output logic signed [nms_pkg::EDGE_W-1:0]  top,
    output logic signed [nms_pkg::EDGE_W-1:0]  right,
    output logic signed [nms_pkg::EDGE_W-1:0]  bottom,
    output logic [nms_pkg::SCORE_W-1:0]        score,
    output logic [nms_pkg::CLASS_W-1:0]        class_id,
    output logic                               overflowed,
    output logic                               last
);

    nms_pkg::cand_t                 mem [nms_pkg::MAX_CAND];

    nms_pkg::back_state_t           state_reg, state_next;
    logic [nms_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           ovf_reg, ovf_next;
    logic [nms_pkg::MAX_CAND-1:0]   alive_reg, alive_next;
    logic [nms_pkg::CNT_W-1:0]      iss_reg, iss_next;
    logic                           found_reg, found_next;
    logic [nms_pkg::SCORE_W-1:0]    best_score_reg, best_score_next;
    logic [nms_pkg::CAND_AW-1:0]    best_idx_reg, best_idx_next;
    nms_pkg::cand_t                 best_data_reg, best_data_next;
    logic                           hold_v_reg, hold_v_next;
    nms_pkg::cand_t                 hold_reg, hold_next;
    logic                           out_v_reg, out_v_next;
    nms_pkg::cand_t                 out_reg, out_next;
    logic                           out_ovf_reg, out_ovf_next;
    logic                           out_last_reg, out_last_next;

    logic                           mem_we;
    logic                           rd_en;

    // Read and suppression pipeline
    logic                           rd_v_reg;
    logic [nms_pkg::CAND_AW-1:0]    rd_idx_reg;
    nms_pkg::cand_t                 rd_data_reg;
    logic                           p1_v_reg, p2_v_reg, p3_v_reg;
    logic [nms_pkg::CAND_AW-1:0]    p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic [nms_pkg::COORD_W-1:0]    p1_iw_reg, p1_ih_reg;
    logic [nms_pkg::AREA_W-1:0]     p1_area_reg, p2_area_reg;
    logic [nms_pkg::AREA_W-1:0]     p2_ov_reg, p3_ov_reg;
    logic [nms_pkg::UNI_W-1:0]      p3_uni_reg;

    logic signed [nms_pkg::EDGE_W-1:0] il, it, ir, ib;
    logic [nms_pkg::EDGE_W-1:0]     dw, dh;
    logic [nms_pkg::PROD_W-1:0]     thr_uni;
    logic [nms_pkg::PROD_W-1:0]     ov_shift;
    logic                           sup;
    logic                           busy;
    logic                           out_free;

    assign out_valid  = out_v_reg;
    assign left       = out_reg.left;
    assign top        = out_reg.top;
    assign right      = out_reg.right;
    assign bottom     = out_reg.bottom;
    assign score      = out_reg.score;
    assign class_id   = out_reg.class_id;
    assign overflowed = out_ovf_reg;
    assign last       = out_last_reg;

    assign busy     = rd_v_reg || p1_v_reg || p2_v_reg || p3_v_reg;
    assign out_free = !out_v_reg || !out_stall;

    // Intersection of the held box with the box read back
    always_comb
    begin
        il = (rd_data_reg.left > hold_reg.left) ? rd_data_reg.left : hold_reg.left;
        it = (rd_data_reg.top > hold_reg.top) ? rd_data_reg.top : hold_reg.top;
        ir = (rd_data_reg.right < hold_reg.right) ? rd_data_reg.right : hold_reg.right;
        ib = (rd_data_reg.bottom < hold_reg.bottom) ? rd_data_reg.bottom : hold_reg.bottom;
        dw = (ir > il) ? (ir - il) : '0;
        dh = (ib > it) ? (ib - it) : '0;
    end

    // Division-free IoU test: overlap * 2^16 > threshold * union
    always_comb
    begin
        thr_uni  = nms_pkg::PROD_W'(iou_thr) * nms_pkg::PROD_W'(p3_uni_reg);
        ov_shift = {1'b0, p3_ov_reg, {nms_pkg::SCORE_W{1'b0}}};
        sup      = ov_shift > thr_uni;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        alive_next      = alive_reg;
        iss_next        = iss_reg;
        found_next      = found_reg;
        best_score_next = best_score_reg;
        best_idx_next   = best_idx_reg;
        best_data_next  = best_data_reg;
        hold_v_next     = hold_v_reg;
        hold_next       = hold_reg;
        out_v_next      = out_v_reg && out_stall;
        out_next        = out_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;

        unique case (state_reg)
            nms_pkg::ST_LOAD:
            begin
                if (!q_stat.empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.is_cand)
                    begin
                        if (cnt_reg < nms_pkg::CNT_W'(nms_pkg::MAX_CAND))
                        begin
                            mem_we = 1'b1;
                            alive_next[cnt_reg[nms_pkg::CAND_AW-1:0]] = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (q_head.is_end && (cnt_next != '0))
                    begin
                        state_next = nms_pkg::ST_SEL;
                        iss_next   = '0;
                        found_next = 1'b0;
                    end
                end
            end
            nms_pkg::ST_SEL:
            begin
                if (iss_reg < cnt_reg)
                begin
                    rd_en    = 1'b1;
                    iss_next = iss_reg + 1'b1;
                end
                else if (!rd_v_reg)
                begin
                    state_next = nms_pkg::ST_PICK;
                end
                // Highest live score, lowest index on ties
                if (rd_v_reg && alive_reg[rd_idx_reg]
                    && (!found_reg || (rd_data_reg.score > best_score_reg)))
                begin
                    found_next      = 1'b1;
                    best_score_next = rd_data_reg.score;
                    best_idx_next   = rd_idx_reg;
                    best_data_next  = rd_data_reg;
                end
            end
            nms_pkg::ST_PICK:
            begin
                if (out_free)
                begin
                    if (found_reg)
                    begin
                        // Release the previous kept box, hold the new one
                        if (hold_v_reg)
                        begin
                            out_v_next    = 1'b1;
                            out_next      = hold_reg;
                            out_ovf_next  = ovf_reg;
                            out_last_next = 1'b0;
                        end
                        hold_v_next = 1'b1;
                        hold_next   = best_data_reg;
                        alive_next[best_idx_reg] = 1'b0;
                        iss_next    = '0;
                        state_next  = nms_pkg::ST_SUPP;
                    end
                    else
                    begin
                        // Nothing left: the held box closes the frame
                        out_v_next    = 1'b1;
                        out_next      = hold_reg;
                        out_ovf_next  = ovf_reg;
                        out_last_next = 1'b1;
                        hold_v_next   = 1'b0;
                        alive_next    = '0;
                        cnt_next      = '0;
                        ovf_next      = 1'b0;
                        state_next    = nms_pkg::ST_LOAD;
                    end
                end
            end
            nms_pkg::ST_SUPP:
            begin
                if (iss_reg < cnt_reg)
                begin
                    rd_en    = 1'b1;
                    iss_next = iss_reg + 1'b1;
                end
                else if (!busy)
                begin
                    iss_next   = '0;
                    found_next = 1'b0;
                    state_next = nms_pkg::ST_SEL;
                end
                if (p3_v_reg && sup)
                begin
                    alive_next[p3_idx_reg] = 1'b0;
                end
            end
            default:
            begin
                state_next = nms_pkg::ST_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nms_pkg::ST_LOAD;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            alive_reg  <= '0;
            iss_reg    <= '0;
            found_reg  <= 1'b0;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            rd_v_reg   <= 1'b0;
            p1_v_reg   <= 1'b0;
            p2_v_reg   <= 1'b0;
            p3_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            alive_reg  <= alive_next;
            iss_reg    <= iss_next;
            found_reg  <= found_next;
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
            rd_v_reg   <= rd_en;
            p1_v_reg   <= rd_v_reg && (state_reg == nms_pkg::ST_SUPP);
            p2_v_reg   <= p1_v_reg;
            p3_v_reg   <= p2_v_reg;
        end
    end

    // Payload registers and pipeline data
    always_ff @(posedge clk)
    begin
        best_score_reg <= best_score_next;
        best_idx_reg   <= best_idx_next;
        best_data_reg  <= best_data_next;
        hold_reg       <= hold_next;
        out_reg        <= out_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;

        rd_idx_reg  <= iss_reg[nms_pkg::CAND_AW-1:0];
        p1_idx_reg  <= rd_idx_reg;
        p1_iw_reg   <= dw[nms_pkg::COORD_W-1:0];
        p1_ih_reg   <= dh[nms_pkg::COORD_W-1:0];
        p1_area_reg <= rd_data_reg.area;
        p2_idx_reg  <= p1_idx_reg;
        p2_ov_reg   <= nms_pkg::AREA_W'(p1_iw_reg) * nms_pkg::AREA_W'(p1_ih_reg);
        p2_area_reg <= p1_area_reg;
        p3_idx_reg  <= p2_idx_reg;
        p3_ov_reg   <= p2_ov_reg;
        p3_uni_reg  <= {1'b0, hold_reg.area} + {1'b0, p2_area_reg} - {1'b0, p2_ov_reg};
    end

    // Candidate memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[nms_pkg::CAND_AW-1:0]] <= q_head.cand;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[iss_reg[nms_pkg::CAND_AW-1:0]];
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= nms_pkg::CNT_W'(nms_pkg::MAX_CAND))
        else $error("candidate count beyond store");
    a_busy_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nms_pkg::ST_LOAD) |-> (cnt_reg != '0))
        else $error("suppression running on an empty frame");
    a_last_has_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nms_pkg::ST_PICK && !found_reg && out_free) |-> hold_v_reg)
        else $error("frame closed without a kept box");

endmodule

// ===== rtl/box_non_max_suppression_top.sv =====
`timescale 1ns / 1ps
// Box non-maximum suppression top level: configuration registers, front end,
// queue and back end. Depends on nms_pkg, nms_front, nms_queue and nms_back.
//
// Usage:
//   Input items (in_valid / in_stall) stream one frame of predictions: a box
//   item (op 0) followed by class score items (op 1), last_class closing a row
//   and last_row with last_class closing the frame. Items are taken one per
//   cycle while the frame loads; in_stall rises only when the four-entry queue
//   to the back end is full, which happens while a previous frame is still
//   being suppressed.
//   Results (out_valid / out_stall) are the kept boxes in descending score
//   order, last set on the final one. Each kept box costs one selection pass
//   and one suppression pass over the N stored candidates; a final selection
//   pass finding none closes the frame, and the single memory read port serialises
//   these passes. A stalled result holds on the outputs and the sequencer
//   waits for it. Configuration (cfg_valid / cfg_ready, always ready) writes
//   the score threshold at index 0 and the IoU threshold at index 1; the user
//   must write them only while idle, which the block itself does not enforce.
//   Reset restores both thresholds to their defaults and empties the store,
//   the queue and the result register; no clearing pass is needed.
module box_non_max_suppression_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [nms_pkg::COORD_W-1:0]        pos_x,
    input  logic [nms_pkg::COORD_W-1:0]        pos_y,
    input  logic [nms_pkg::COORD_W-1:0]        box_width,
    input  logic [nms_pkg::COORD_W-1:0]        box_height,
    input  logic [nms_pkg::SCORE_W-1:0]        objectness,
    input  logic [nms_pkg::SCORE_W-1:0]        class_score,
    input  logic                               last_class,
    input  logic                               last_row,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [nms_pkg::EDGE_W-1:0]  left,
    output logic signed [nms_pkg::EDGE_W-1:0]  top,
    output logic signed [nms_pkg::EDGE_W-1:0]  right,
    output logic signed [nms_pkg::EDGE_W-1:0]  bottom,
    output logic [nms_pkg::SCORE_W-1:0]        score,
    output logic [nms_pkg::CLASS_W-1:0]        class_id,
    output logic                               overflowed,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nms_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [nms_pkg::SCORE_W-1:0]        cfg_data
);

    logic [nms_pkg::SCORE_W-1:0] score_thr_reg;
    logic [nms_pkg::SCORE_W-1:0] iou_thr_reg;
    logic                        q_push;
    logic                        q_pop;
    nms_pkg::q_entry_t           q_data;
    nms_pkg::q_entry_t           q_head;
    nms_pkg::q_stat_t            q_stat;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg <= nms_pkg::SCORE_THR_RST;
            iou_thr_reg   <= nms_pkg::IOU_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nms_pkg::REG_SCORE_THR: score_thr_reg <= cfg_data;
                nms_pkg::REG_IOU_THR:   iou_thr_reg   <= cfg_data;
                default:                score_thr_reg <= score_thr_reg;
            endcase
        end
    end

    nms_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .box_width   (box_width),
        .box_height  (box_height),
        .objectness  (objectness),
        .class_score (class_score),
        .last_class  (last_class),
        .last_row    (last_row),
        .score_thr   (score_thr_reg),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    nms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    nms_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .iou_thr    (iou_thr_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left       (left),
        .top        (top),
        .right      (right),
        .bottom     (bottom),
        .score      (score),
        .class_id   (class_id),
        .overflowed (overflowed),
        .last       (last)
    );

endmodule
